FILE: hw/rtl/row_softmax_top_defines.svh
`ifndef ROW_SOFTMAX_TOP_DEFINES_SVH
`define ROW_SOFTMAX_TOP_DEFINES_SVH

// same-cycle implication on the checker clock
`define RSM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("row softmax check failed");

// next-cycle implication on the checker clock
`define RSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("row softmax check failed");

`endif

FILE: hw/rtl/rsm_pkg.sv
`timescale 1ns / 1ps
package rsm_pkg;

	localparam int SCORE_BITS = 16;
	localparam int PROB_BITS  = 16;
	localparam int EXP_BITS   = 16;
	localparam int RECIP_BITS = 40;
	localparam int QUO_BITS   = 26;
	localparam int K_BITS     = 13;
	localparam int T_BITS     = 13;
	localparam int EXP_LIMIT  = 4096;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;

	typedef struct packed {
		logic signed [SCORE_BITS-1:0] score;
		logic                         row_last;
	} item_t;

	typedef struct packed {
		logic [PROB_BITS-1:0] probability;
		logic                 result_last;
		logic                 row_overflow;
	} result_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SUM_RD,
		ST_SUM_EX1,
		ST_SUM_EX2,
		ST_SUM_ACC,
		ST_DIV,
		ST_OUT_RD,
		ST_OUT_EX1,
		ST_OUT_EX2,
		ST_OUT_MUL,
		ST_OUT_PUT,
		ST_OUT_WAIT
	} state_t;

	typedef struct packed {
		logic load;
		logic close;
		logic acc;
		logic idx_inc;
		logic idx_clr;
		logic div_init;
		logic div_step;
		logic put;
		logic row_clr;
	} cmd_t;

	typedef struct packed {
		logic last_idx;
		logic div_done;
	} status_t;

	// 32768 * 2^(-j/16)
	function automatic logic [15:0] pow2_tab(input logic [4:0] j);
		logic [15:0] v;
		unique case (j)
			5'd0:  v = 16'd32768;
			5'd1:  v = 16'd31379;
			5'd2:  v = 16'd30048;
			5'd3:  v = 16'd28774;
			5'd4:  v = 16'd27554;
			5'd5:  v = 16'd26386;
			5'd6:  v = 16'd25268;
			5'd7:  v = 16'd24196;
			5'd8:  v = 16'd23170;
			5'd9:  v = 16'd22188;
			5'd10: v = 16'd21247;
			5'd11: v = 16'd20347;
			5'd12: v = 16'd19484;
			5'd13: v = 16'd18658;
			5'd14: v = 16'd17867;
			5'd15: v = 16'd17110;
			5'd16: v = 16'd16384;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/row_softmax_top.sv
`timescale 1ns / 1ps
// Row softmax over signed Q8.8 scores. Scores of a row are taken one per cycle
// into a MAX_CLASSES-entry row buffer; extra scores are dropped and flagged on
// every result of that row. After the score marked last, the block makes one
// exp pass over the buffer (read, two exp stages, accumulate per score), a
// reciprocal, then emits one Q0.16 probability per stored score, each held by
// any output stall. The item channel stalls from the close of a row until its
// last result is taken; the per-score cost is set by the shared exp unit and
// the one-port row buffer read.
module row_softmax_top #(
	parameter int MAX_CLASSES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  rsm_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output rsm_pkg::result_t  result
);

	rsm_pkg::cmd_t    cmd;
	rsm_pkg::status_t status;
	logic             item_fire;
	logic             result_fire;

	assign item_fire   = item_valid && !item_stall;
	assign result_fire = result_valid && !result_stall;

	rsm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_fire   (item_fire),
		.item_last   (item.row_last),
		.result_fire (result_fire),
		.status      (status),
		.item_stall  (item_stall),
		.cmd         (cmd)
	);

	rsm_dp #(
		.MAX_CLASSES (MAX_CLASSES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.status       (status)
	);

endmodule

FILE: hw/rtl/rsm_ctrl.sv
`timescale 1ns / 1ps
module rsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_fire,
	input  logic              item_last,
	input  logic              result_fire,
	input  rsm_pkg::status_t  status,
	output logic              item_stall,
	output rsm_pkg::cmd_t     cmd
);

	rsm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsm_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsm_pkg::ST_LOAD: begin
				if (item_fire && item_last) state_d = rsm_pkg::ST_SUM_RD;
			end
			rsm_pkg::ST_SUM_RD:  state_d = rsm_pkg::ST_SUM_EX1;
			rsm_pkg::ST_SUM_EX1: state_d = rsm_pkg::ST_SUM_EX2;
			rsm_pkg::ST_SUM_EX2: state_d = rsm_pkg::ST_SUM_ACC;
			rsm_pkg::ST_SUM_ACC: begin
				state_d = status.last_idx ? rsm_pkg::ST_DIV : rsm_pkg::ST_SUM_RD;
			end
			rsm_pkg::ST_DIV: begin
				if (status.div_done) state_d = rsm_pkg::ST_OUT_RD;
			end
			rsm_pkg::ST_OUT_RD:  state_d = rsm_pkg::ST_OUT_EX1;
			rsm_pkg::ST_OUT_EX1: state_d = rsm_pkg::ST_OUT_EX2;
			rsm_pkg::ST_OUT_EX2: state_d = rsm_pkg::ST_OUT_MUL;
			rsm_pkg::ST_OUT_MUL: state_d = rsm_pkg::ST_OUT_PUT;
			rsm_pkg::ST_OUT_PUT: state_d = rsm_pkg::ST_OUT_WAIT;
			rsm_pkg::ST_OUT_WAIT: begin
				if (result_fire) begin
					state_d = status.last_idx ? rsm_pkg::ST_LOAD : rsm_pkg::ST_OUT_RD;
				end
			end
			default: state_d = rsm_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			rsm_pkg::ST_LOAD: begin
				item_stall = 1'b0;
				cmd.load   = item_fire;
				cmd.close  = item_fire && item_last;
			end
			rsm_pkg::ST_SUM_ACC: begin
				cmd.acc      = 1'b1;
				cmd.idx_inc  = !status.last_idx;
				cmd.div_init = status.last_idx;
			end
			rsm_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.idx_clr  = status.div_done;
			end
			rsm_pkg::ST_OUT_PUT: begin
				cmd.put = 1'b1;
			end
			rsm_pkg::ST_OUT_WAIT: begin
				cmd.idx_inc = result_fire && !status.last_idx;
				cmd.row_clr = result_fire && status.last_idx;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: hw/rtl/rsm_dp.sv
`timescale 1ns / 1ps
module rsm_dp #(
	parameter int MAX_CLASSES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rsm_pkg::item_t    item,
	input  rsm_pkg::cmd_t     cmd,
	input  logic              result_stall,
	output logic              result_valid,
	output rsm_pkg::result_t  result,
	output rsm_pkg::status_t  status
);

	localparam int IDX_BITS  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int FILL_BITS = $clog2(MAX_CLASSES + 1);
	localparam int SUM_BITS  = rsm_pkg::EXP_BITS + IDX_BITS;
	localparam int REM_BITS  = SUM_BITS + 1;
	localparam int CNT_BITS  = $clog2(rsm_pkg::RECIP_BITS + 1);
	localparam int PROD_BITS = rsm_pkg::EXP_BITS + rsm_pkg::QUO_BITS;
	localparam int SB        = rsm_pkg::SCORE_BITS;

	logic signed [SB-1:0] mem [MAX_CLASSES];
	logic signed [SB-1:0] rd_q;
	logic signed [SB-1:0] max_q;
	logic [FILL_BITS-1:0] fill_q;
	logic [IDX_BITS-1:0]  idx_q;
	logic [SUM_BITS-1:0]  sum_q;
	logic                 ovf_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [rsm_pkg::QUO_BITS-1:0] quo_q;
	logic [CNT_BITS-1:0]  cnt_q;

	logic [rsm_pkg::T_BITS-1:0] t_s1;
	logic                       far_s1;
	logic [rsm_pkg::EXP_BITS-1:0] e_s2;
	logic [PROD_BITS-1:0]       prod_s3;

	logic                 room;
	logic signed [SB:0]   diff;
	logic [SB-1:0]        k;
	logic [29:0]          t_prod;
	logic [4:0]           n;
	logic [3:0]           j;
	logic [3:0]           r;
	logic [15:0]          tj;
	logic [15:0]          tj1;
	logic [14:0]          drop_mul;
	logic [15:0]          m;
	logic [23:0]          rnd;
	logic [23:0]          shifted;
	logic [REM_BITS-1:0]  rem_sh;
	logic [rsm_pkg::QUO_BITS-1:0] recip;
	logic [PROD_BITS-1:0] p_round;
	logic [PROD_BITS-rsm_pkg::RECIP_BITS+rsm_pkg::PROB_BITS-1:0] p_full;
	logic [rsm_pkg::PROB_BITS-1:0] p_sat;

	assign room = fill_q < FILL_BITS'(MAX_CLASSES);

	// row buffer
	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			mem[fill_q[IDX_BITS-1:0]] <= item.score;
		end
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= {1'b1, {(SB-1){1'b0}}};
			fill_q <= '0;
			ovf_q  <= 1'b0;
			idx_q  <= '0;
			sum_q  <= '0;
		end else begin
			if (cmd.row_clr) begin
				max_q  <= {1'b1, {(SB-1){1'b0}}};
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end else if (cmd.load) begin
				if (room) begin
					fill_q <= fill_q + 1'b1;
					if (item.score > max_q) max_q <= item.score;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.close || cmd.idx_clr || cmd.row_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.close) begin
				sum_q <= '0;
			end else if (cmd.acc) begin
				sum_q <= sum_q + SUM_BITS'(e_s2);
			end
		end
	end

	assign status.last_idx = ({1'b0, idx_q} + 1'b1) == (IDX_BITS + 1)'(fill_q);

	// exp stage 1: distance below max, scaled by log2(e)
	assign diff   = {max_q[SB-1], max_q} - {rd_q[SB-1], rd_q};
	assign k      = diff[SB-1:0];
	assign t_prod = 30'(k[rsm_pkg::K_BITS-1:0]) * 30'(rsm_pkg::LOG2E_Q16) + 30'd32768;

	always_ff @(posedge clk) begin
		far_s1 <= k > SB'(rsm_pkg::EXP_LIMIT);
		t_s1   <= t_prod[16 +: rsm_pkg::T_BITS];
	end

	// exp stage 2: table interpolation and power-of-two shift
	assign n        = t_s1[12:8];
	assign j        = t_s1[7:4];
	assign r        = t_s1[3:0];
	assign tj       = rsm_pkg::pow2_tab({1'b0, j});
	assign tj1      = rsm_pkg::pow2_tab({1'b0, j} + 5'd1);
	assign drop_mul = 15'(tj - tj1) * 15'(r) + 15'd8;
	assign m        = tj - 16'(drop_mul[14:4]);
	assign rnd      = (n == 5'd0) ? 24'd0 : (24'd1 << (n - 5'd1));
	assign shifted  = ({8'd0, m} + rnd) >> n;

	always_ff @(posedge clk) begin
		e_s2 <= far_s1 ? '0 : shifted[rsm_pkg::EXP_BITS-1:0];
	end

	// restoring divider for 2^40 / sum, one quotient bit per cycle
	assign rem_sh          = {rem_q[REM_BITS-2:0], (cnt_q == '0)};
	assign status.div_done = cnt_q == CNT_BITS'(rsm_pkg::RECIP_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_init) begin
			cnt_q <= '0;
		end else if (cmd.div_step && !status.div_done) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_sh >= {1'b0, sum_q}) begin
				rem_q <= rem_sh - {1'b0, sum_q};
				quo_q <= {quo_q[rsm_pkg::QUO_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[rsm_pkg::QUO_BITS-2:0], 1'b0};
			end
		end
	end

	// zero sum guard
	assign recip = (sum_q == '0) ? '0 : quo_q;

	always_ff @(posedge clk) begin
		prod_s3 <= PROD_BITS'(e_s2) * PROD_BITS'(recip);
	end

	assign p_round = prod_s3
		+ (PROD_BITS'(1) << (rsm_pkg::RECIP_BITS - rsm_pkg::PROB_BITS - 1));
	assign p_full  = p_round[PROD_BITS-1 : rsm_pkg::RECIP_BITS - rsm_pkg::PROB_BITS];
	assign p_sat   = (p_full > {1'b0, {rsm_pkg::PROB_BITS{1'b1}}}) ? '1
		: p_full[rsm_pkg::PROB_BITS-1:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (cmd.put) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			result.probability  <= p_sat;
			result.result_last  <= status.last_idx;
			result.row_overflow <= ovf_q;
		end
	end

endmodule

FILE: hw/rtl/rsm_checker.sv
`timescale 1ns / 1ps
`include "row_softmax_top_defines.svh"
module rsm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input rsm_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input rsm_pkg::result_t result
);

	// a held result keeps its value
	`RSM_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
	// no item is taken while a result is pending
	`RSM_ASSERT_NOW(a_no_overlap, result_valid, item_stall)
	// closing a row blocks further items
	`RSM_ASSERT_NEXT(a_close_stalls, item_valid && !item_stall && item.row_last, item_stall)
	// the last result of a row ends emission
	`RSM_ASSERT_NEXT(a_last_ends, result_valid && !result_stall && result.result_last,
		!result_valid)

endmodule

bind row_softmax_top rsm_checker u_rsm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
